// ===== sv/bgw_pkg.sv =====
// ----------------------------------------------------------------------------
// bgw_pkg
// Shared constants, opcodes and symbol mapping for the bigram graph walk.
// ----------------------------------------------------------------------------
package bgw_pkg;

    localparam int SYMBOL_COUNT_DEF = 28;
    localparam int COUNT_BITS_DEF   = 16;

    localparam logic [1:0] OP_TEXT   = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam logic [5:0] SYM_LAST_LETTER = 6'd25;
    localparam logic [5:0] SYM_DOT         = 6'd26;
    localparam logic [5:0] SYM_SPACE       = 6'd27;

    typedef struct packed {
        logic       ok;
        logic [5:0] idx;
    } t_sym_map;

    // Fold case and map a byte to its symbol index.
    function automatic t_sym_map to_symbol(logic [7:0] code);
        t_sym_map   m;
        logic [7:0] c;
        c     = code;
        m.ok  = 1'b1;
        m.idx = '0;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            c = c - CH_UPPER_A + CH_LOWER_A;
        end
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            m.idx = 6'(c - CH_LOWER_A);
        end else if (c == CH_DOT) begin
            m.idx = SYM_DOT;
        end else if (c == CH_SPACE) begin
            m.idx = SYM_SPACE;
        end else begin
            m.ok = 1'b0;
        end
        return m;
    endfunction

    function automatic logic [7:0] sym_to_byte(logic [5:0] s);
        logic [7:0] b;
        if (s <= SYM_LAST_LETTER) begin
            b = CH_LOWER_A + 8'(s);
        end else if (s == SYM_DOT) begin
            b = CH_DOT;
        end else begin
            b = CH_SPACE;
        end
        return b;
    endfunction

endpackage

// ===== sv/bgw_ram.sv =====
// ----------------------------------------------------------------------------
// bgw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bgw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 28
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/bigram_graph_best_first_walk.sv =====
// ----------------------------------------------------------------------------
// bigram_graph_best_first_walk
// Bigram counting over a text stream and greedy best-first walk on the counts.
// ----------------------------------------------------------------------------
// Opcode 0 words feed text bytes; each kept byte with a predecessor is read
// and then written back as a saturating increment of one pair count in the
// count RAM (a byte that is skipped or has no predecessor is not counted).
// Opcode 2 clears all SYMBOL_COUNT*SYMBOL_COUNT entries of the count RAM
// (784 by default) at one entry per cycle, and the same pass runs after
// reset; no word is taken meanwhile. A search (opcode 1) runs two scans per
// visited symbol, one over the best-weight RAM to pick and one over the
// picked row of the count RAM to update, plus a final scan; a stalled output
// holds it back. Results go out in visit order; a bad start gives a single
// word with o_bad_start and o_last_of_run set.
module bigram_graph_best_first_walk #(
    parameter int SYMBOL_COUNT = bgw_pkg::SYMBOL_COUNT_DEF,
    parameter int COUNT_BITS   = bgw_pkg::COUNT_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_char_code,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_symbol_code,
    output logic       o_bad_start,
    output logic       o_last_of_run
);
    import bgw_pkg::*;

    localparam int SYM_W = $clog2(SYMBOL_COUNT);
    localparam int PAIRS = SYMBOL_COUNT * SYMBOL_COUNT;
    localparam int AW    = $clog2(PAIRS);

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_TXT   = 3'd2;
    localparam logic [2:0] S_SEL   = 3'd3;
    localparam logic [2:0] S_PICK  = 3'd4;
    localparam logic [2:0] S_UPD   = 3'd5;
    localparam logic [2:0] S_FLUSH = 3'd6;

    logic [2:0]            r_state;
    logic [AW-1:0]         r_caddr, r_taddr, r_base;
    logic [SYM_W-1:0]      r_prev, r_idx, r_rd_idx, r_pick, r_pend;
    logic                  r_prev_v, r_scan, r_rd_v, r_rd_last, r_found, r_has_pend, r_bad;
    logic [COUNT_BITS-1:0] r_pick_w;
    logic [SYMBOL_COUNT-1:0] r_reached, r_visited;
    logic                  r_out_valid, r_out_bad, r_out_last;
    logic [7:0]            r_out_sym;

    t_sym_map              in_map;
    logic                  in_ok;
    logic [SYM_W-1:0]      in_sym;
    logic [AW-1:0]         text_addr;
    logic                  slot_free;

    logic                  pc_we;
    logic [AW-1:0]         pc_waddr, pc_raddr;
    logic [COUNT_BITS-1:0] pc_wdata, pc_rdata;
    logic                  bw_we;
    logic [SYM_W-1:0]      bw_waddr;
    logic [COUNT_BITS-1:0] bw_wdata, bw_rdata;

    logic                  cand, take, upd_hit;
    logic                  n_found;
    logic [SYM_W-1:0]      n_pick;
    logic [COUNT_BITS-1:0] n_pick_w;

    assign in_map    = to_symbol(i_char_code);
    assign in_ok     = in_map.ok && (7'(in_map.idx) < 7'(SYMBOL_COUNT));
    assign in_sym    = SYM_W'(in_map.idx);
    assign text_addr = AW'(r_prev) * AW'(SYMBOL_COUNT) + AW'(in_sym);
    assign slot_free = !r_out_valid || !i_stall;

    // pick compare over the best-weight scan; ties go to the higher index
    assign cand     = r_reached[r_rd_idx] && !r_visited[r_rd_idx];
    assign take     = r_rd_v && cand && (!r_found || bw_rdata >= r_pick_w);
    assign n_found  = r_found || take;
    assign n_pick   = take ? r_rd_idx : r_pick;
    assign n_pick_w = take ? bw_rdata : r_pick_w;

    assign upd_hit = r_rd_v && !r_visited[r_rd_idx] && (pc_rdata != '0)
                     && (!r_reached[r_rd_idx] || pc_rdata > bw_rdata);

    always_comb begin
        pc_we    = 1'b0;
        pc_waddr = r_caddr;
        pc_wdata = '0;
        if (r_state == S_CLR) begin
            pc_we = 1'b1;
        end else if (r_state == S_TXT) begin
            pc_we    = 1'b1;
            pc_waddr = r_taddr;
            pc_wdata = (pc_rdata == '1) ? pc_rdata : pc_rdata + 1'b1;
        end
        pc_raddr = (r_state == S_IDLE) ? text_addr : r_base + AW'(r_idx);
    end

    always_comb begin
        bw_we    = 1'b0;
        bw_waddr = r_rd_idx;
        bw_wdata = pc_rdata;
        if (r_state == S_IDLE && i_valid && i_opcode == OP_SEARCH && in_ok) begin
            bw_we    = 1'b1;
            bw_waddr = in_sym;
            bw_wdata = '0;
        end else if (r_state == S_UPD && upd_hit) begin
            bw_we = 1'b1;
        end
    end

    bgw_ram #(.WIDTH(COUNT_BITS), .DEPTH(PAIRS)) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (pc_we),
        .i_waddr (pc_waddr),
        .i_wdata (pc_wdata),
        .i_raddr (pc_raddr),
        .o_rdata (pc_rdata)
    );

    bgw_ram #(.WIDTH(COUNT_BITS), .DEPTH(SYMBOL_COUNT)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (bw_we),
        .i_waddr (bw_waddr),
        .i_wdata (bw_wdata),
        .i_raddr (r_idx),
        .o_rdata (bw_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_caddr     <= '0;
            r_prev      <= '0;
            r_prev_v    <= 1'b0;
            r_reached   <= '0;
            r_visited   <= '0;
            r_scan      <= 1'b0;
            r_rd_v      <= 1'b0;
            r_found     <= 1'b0;
            r_has_pend  <= 1'b0;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            // read pipeline shared by both scans
            if (r_scan) begin
                r_rd_v    <= 1'b1;
                r_rd_idx  <= r_idx;
                r_rd_last <= (r_idx == SYM_W'(SYMBOL_COUNT - 1));
                if (r_idx == SYM_W'(SYMBOL_COUNT - 1)) begin
                    r_scan <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end else begin
                r_rd_v <= 1'b0;
            end

            case (r_state)
                S_CLR: begin
                    r_caddr <= r_caddr + 1'b1;
                    if (r_caddr == AW'(PAIRS - 1)) begin
                        r_caddr <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        case (i_opcode)
                            OP_TEXT: begin
                                if (in_ok) begin
                                    r_prev   <= in_sym;
                                    r_prev_v <= 1'b1;
                                    if (r_prev_v) begin
                                        r_taddr <= text_addr;
                                        r_state <= S_TXT;
                                    end
                                end
                            end
                            OP_SEARCH: begin
                                if (in_ok) begin
                                    r_reached  <= SYMBOL_COUNT'(1) << in_sym;
                                    r_visited  <= '0;
                                    r_has_pend <= 1'b0;
                                    r_bad      <= 1'b0;
                                    r_found    <= 1'b0;
                                    r_scan     <= 1'b1;
                                    r_idx      <= '0;
                                    r_state    <= S_SEL;
                                end else begin
                                    r_bad   <= 1'b1;
                                    r_state <= S_FLUSH;
                                end
                            end
                            OP_CLEAR: begin
                                r_prev   <= '0;
                                r_prev_v <= 1'b0;
                                r_state  <= S_CLR;
                            end
                            default: ;
                        endcase
                    end
                end
                S_TXT: begin
                    r_state <= S_IDLE;
                end
                S_SEL: begin
                    if (r_rd_v) begin
                        r_found  <= n_found;
                        r_pick   <= n_pick;
                        r_pick_w <= n_pick_w;
                        if (r_rd_last) begin
                            r_state <= n_found ? S_PICK : S_FLUSH;
                        end
                    end
                end
                S_PICK: begin
                    // the previous pick is known not to be last: send it now
                    if (!r_has_pend || slot_free) begin
                        if (r_has_pend) begin
                            r_out_valid <= 1'b1;
                            r_out_sym   <= sym_to_byte(6'(r_pend));
                            r_out_bad   <= 1'b0;
                            r_out_last  <= 1'b0;
                        end
                        r_visited[r_pick] <= 1'b1;
                        r_pend     <= r_pick;
                        r_has_pend <= 1'b1;
                        r_base     <= AW'(r_pick) * AW'(SYMBOL_COUNT);
                        r_scan     <= 1'b1;
                        r_idx      <= '0;
                        r_state    <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (upd_hit) begin
                        r_reached[r_rd_idx] <= 1'b1;
                    end
                    if (r_rd_v && r_rd_last) begin
                        r_found <= 1'b0;
                        r_scan  <= 1'b1;
                        r_idx   <= '0;
                        r_state <= S_SEL;
                    end
                end
                S_FLUSH: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_sym   <= r_bad ? 8'h00 : sym_to_byte(6'(r_pend));
                        r_out_bad   <= r_bad;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_symbol_code = r_out_sym;
    assign o_bad_start   = r_out_bad;
    assign o_last_of_run = r_out_last;

    a_visited_reached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_visited & ~r_reached) == '0)
        else $error("visited symbol not reached");

    a_bad_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_start |-> o_last_of_run && o_symbol_code == 8'h00)
        else $error("bad start word malformed");

    a_txt_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_TXT |=> r_state == S_IDLE)
        else $error("count write-back not single cycle");

    a_pick_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PICK |-> r_found)
        else $error("pick without candidate");

endmodule
